/* sv/oan_pkg.sv */
package oan_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_REV   = 3'd2,
    MODE_AVOID = 3'd3,
    MODE_TURN  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_FWD    = 3'd1,
    CMD_BACK   = 3'd2,
    CMD_SPIN_R = 3'd3,
    CMD_SPIN_L = 3'd4,
    CMD_TURN_R = 3'd5,
    CMD_TURN_L = 3'd6,
    CMD_STOP   = 3'd7
  } cmd_t;

  localparam logic [1:0] ACT_TICK       = 2'd0;
  localparam logic [1:0] ACT_ACTIVATE   = 2'd1;
  localparam logic [1:0] ACT_DEACTIVATE = 2'd2;

  localparam logic [1:0] ZONE_CLEAR  = 2'd0;
  localparam logic [1:0] ZONE_DANGER = 2'd2;

  localparam logic [1:0] REG_REVERSE_MS   = 2'd0;
  localparam logic [1:0] REG_AVOID_TO_MS  = 2'd1;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd2;
  localparam logic [1:0] REG_SLOW_SPEED   = 2'd3;

  localparam logic [15:0] RST_REVERSE_MS   = 16'd500;
  localparam logic [15:0] RST_AVOID_TO_MS  = 16'd5000;
  localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd3;
  localparam logic [6:0]  RST_SLOW_SPEED   = 7'd50;

  localparam logic [15:0] MIN_SPIN_MS = 16'd300;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] reverse_ms;
    logic [15:0] spin_timeout_ms;
    logic [3:0]  max_attempts;
    logic [6:0]  slow_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  zone;
    logic [6:0]  adjusted_speed;
    logic        rand_dir;
    logic [9:0]  rand_turn_ms;
    logic [12:0] rand_explore_ms;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        running;
    logic [15:0] elapsed_ms;
    logic [9:0]  turn_length;
    logic        turn_right;
    logic [3:0]  attempt_count;
    logic [12:0] explore_left;
  } nav_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] speed;
  } res_t;

endpackage

/* sv/oan_cfg.sv */
module oan_cfg
  import oan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_ms      <= RST_REVERSE_MS;
      cfg.spin_timeout_ms <= RST_AVOID_TO_MS;
      cfg.max_attempts    <= RST_MAX_ATTEMPTS;
      cfg.slow_speed      <= RST_SLOW_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REVERSE_MS:   cfg.reverse_ms      <= cfg_data;
        REG_AVOID_TO_MS:  cfg.spin_timeout_ms <= cfg_data;
        REG_MAX_ATTEMPTS: cfg.max_attempts    <= cfg_data[3:0];
        REG_SLOW_SPEED:   cfg.slow_speed      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/oan_step.sv */
module oan_step
  import oan_pkg::*;
(
  input  cfg_t       cfg,
  input  item_t      item,
  input  nav_state_t cur,
  output nav_state_t nxt,
  output res_t       res
);

  logic        critical;
  logic        safe;
  logic [15:0] elapsed_inc;
  logic [12:0] explore_dec;
  logic [3:0]  attempt_inc;
  logic        rev_done;
  logic        avoid_timeout;
  logic        avoid_give_up;
  logic        avoid_clear;
  logic        turn_busy;
  logic        tick;

  assign critical      = item.zone >= ZONE_DANGER;
  assign safe          = item.zone == ZONE_CLEAR;
  assign tick          = (item.action == ACT_TICK) && cur.running;
  assign elapsed_inc   = (cur.elapsed_ms < ELAPSED_MAX) ? cur.elapsed_ms + 16'd1
                                                        : cur.elapsed_ms;
  assign explore_dec   = (cur.explore_left != 13'd0) ? cur.explore_left - 13'd1
                                                     : cur.explore_left;
  assign attempt_inc   = cur.attempt_count + 4'd1;
  assign rev_done      = elapsed_inc >= cfg.reverse_ms;
  assign avoid_timeout = elapsed_inc >= cfg.spin_timeout_ms;
  assign avoid_give_up = attempt_inc >= cfg.max_attempts;
  assign avoid_clear   = (elapsed_inc >= MIN_SPIN_MS) && safe;
  assign turn_busy     = elapsed_inc < {6'd0, cur.turn_length};

  // next state
  always_comb begin
    nxt = cur;
    if (item.action == ACT_ACTIVATE) begin
      if (!cur.running) begin
        nxt.running      = 1'b1;
        nxt.mode         = MODE_FWD;
        nxt.elapsed_ms   = 16'd0;
        nxt.explore_left = item.rand_explore_ms;
      end
    end else if (item.action == ACT_DEACTIVATE) begin
      if (cur.running) begin
        nxt.running    = 1'b0;
        nxt.mode       = MODE_IDLE;
        nxt.elapsed_ms = 16'd0;
      end
    end else if (tick) begin
      nxt.elapsed_ms   = elapsed_inc;
      nxt.explore_left = explore_dec;
      unique case (cur.mode)
        MODE_FWD: begin
          if (critical) begin
            nxt.mode       = MODE_REV;
            nxt.elapsed_ms = 16'd0;
          end else if (explore_dec == 13'd0) begin
            nxt.mode        = MODE_TURN;
            nxt.elapsed_ms  = 16'd0;
            nxt.turn_length = item.rand_turn_ms;
            nxt.turn_right  = item.rand_dir;
          end
        end
        MODE_REV: begin
          if (rev_done) begin
            nxt.mode          = MODE_AVOID;
            nxt.elapsed_ms    = 16'd0;
            nxt.attempt_count = 4'd0;
            nxt.turn_right    = item.rand_dir;
          end
        end
        MODE_AVOID: begin
          if (avoid_timeout) begin
            nxt.elapsed_ms = 16'd0;
            if (avoid_give_up) begin
              nxt.mode          = MODE_REV;
              nxt.attempt_count = 4'd0;
            end else begin
              nxt.attempt_count = attempt_inc;
              nxt.turn_right    = ~cur.turn_right;
            end
          end else if (avoid_clear) begin
            nxt.mode         = MODE_FWD;
            nxt.elapsed_ms   = 16'd0;
            nxt.explore_left = item.rand_explore_ms;
          end
        end
        MODE_TURN: begin
          if (critical) begin
            nxt.mode       = MODE_REV;
            nxt.elapsed_ms = 16'd0;
          end else if (!turn_busy) begin
            nxt.mode         = MODE_FWD;
            nxt.elapsed_ms   = 16'd0;
            nxt.explore_left = item.rand_explore_ms;
          end
        end
        default: ;
      endcase
    end
  end

  // motor command
  always_comb begin
    res.cmd   = CMD_NONE;
    res.speed = 7'd0;
    if (item.action == ACT_DEACTIVATE) begin
      if (cur.running) begin
        res.cmd = CMD_STOP;
      end
    end else if (tick) begin
      unique case (cur.mode)
        MODE_FWD: begin
          if (!critical) begin
            res.cmd   = CMD_FWD;
            res.speed = item.adjusted_speed;
          end
        end
        MODE_REV: begin
          if (rev_done) begin
            res.cmd = CMD_STOP;
          end else begin
            res.cmd   = CMD_BACK;
            res.speed = cfg.slow_speed;
          end
        end
        MODE_AVOID: begin
          if (avoid_timeout) begin
            if (avoid_give_up) begin
              res.cmd = CMD_STOP;
            end
          end else if (avoid_clear) begin
            res.cmd = CMD_STOP;
          end else begin
            res.cmd   = cur.turn_right ? CMD_SPIN_R : CMD_SPIN_L;
            res.speed = cfg.slow_speed;
          end
        end
        MODE_TURN: begin
          if (!critical) begin
            if (turn_busy) begin
              res.cmd   = cur.turn_right ? CMD_TURN_R : CMD_TURN_L;
              res.speed = cfg.slow_speed;
            end else begin
              res.cmd = CMD_STOP;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/obstacle_avoid_navigator.sv */
// Navigation sequencer for an obstacle-avoiding robot.
// Input channel (in_valid/in_ready): one item per activate, deactivate or
// 1 ms tick, with the sensor zone, adjusted speed and random choices.
// Output channel (out_valid/out_ready): one item per input item carrying the
// motor command, its speed and the navigation state after the step.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no item is in flight.
// Flow: an accepted item is registered in the input register, then stepped
// against the state as it moves into the result register, where it is valid.
// Throughput: one item per cycle while out_ready is high; the state update
// is one pass of compares and counter steps from input to result register.
// Stall: when out_ready is low the result register holds, the input register
// fills behind it, and in_ready drops until the result is taken.
// Reset (rst, synchronous): both stages empty, state idle and not running,
// timers and counters cleared, registers back to their defaults.
module obstacle_avoid_navigator
  import oan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  zone,
  input  logic [6:0]  adjusted_speed,
  input  logic        rand_dir,
  input  logic [9:0]  rand_turn_ms,
  input  logic [12:0] rand_explore_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  motor_cmd,
  output logic [6:0]  motor_speed,
  output logic [2:0]  nav_state
);

  cfg_t       cfg;
  item_t      item;
  logic       item_valid;
  nav_state_t st;
  nav_state_t st_next;
  res_t       res_next;
  res_t       res;
  logic       advance;

  oan_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oan_step u_step (
    .cfg  (cfg),
    .item (item),
    .cur  (st),
    .nxt  (st_next),
    .res  (res_next)
  );

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{action, zone, adjusted_speed, rand_dir, rand_turn_ms, rand_explore_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode          <= MODE_IDLE;
      st.running       <= 1'b0;
      st.elapsed_ms    <= 16'd0;
      st.turn_length   <= 10'd0;
      st.turn_right    <= 1'b0;
      st.attempt_count <= 4'd0;
      st.explore_left  <= 13'd0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res       <= res_next;
      nav_state <= st_next.mode;
    end
  end

  assign motor_cmd   = res.cmd;
  assign motor_speed = res.speed;

`ifndef NO_ASSERTIONS
  a_idle_not_running: assert property (@(posedge clk) disable iff (rst)
    (st.running == 1'b0) |-> (st.mode == MODE_IDLE))
    else $error("idle mode and running flag disagree");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("stepped item did not reach the result register");

  a_quiet_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (res.cmd == CMD_NONE || res.cmd == CMD_STOP)) |-> (res.speed == 7'd0))
    else $error("nonzero speed with no motion command");

  a_fwd_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.cmd == CMD_FWD) |->
      (nav_state == MODE_FWD || nav_state == MODE_TURN))
    else $error("forward command outside forward or turning");
`endif

endmodule
